// ===== rtl/fpba_pkg.sv =====
// Shared types and constants for the fit-policy block allocator.
// Used by fpba_ram and fit_policy_block_allocator; no dependencies.
`default_nettype none

package fpba_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 16;
  localparam int WORD_BYTES   = 8;
  localparam int ADDR_BITS    = 16;
  localparam int SIZE_BITS    = 17;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  // fit policies
  localparam logic [1:0] POL_BEST  = 2'd0;
  localparam logic [1:0] POL_WORST = 2'd1;
  localparam logic [1:0] POL_FIRST = 2'd2;
  localparam logic [1:0] POL_NEXT  = 2'd3;

  // request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // configuration register indexes
  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_REGION = 1'b1;

  typedef struct packed {
    logic                 in_use;
    logic [ADDR_BITS-1:0] dsize;
    logic [ADDR_BITS-1:0] offset;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/fpba_ram.sv =====
// Block table storage: one write port, one read port, registered read data.
// Depends on fpba_pkg for the entry layout.
`default_nettype none

module fpba_ram #(
  parameter int DEPTH = fpba_pkg::MAX_BLOCKS
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  fpba_pkg::entry_t        wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output fpba_pkg::entry_t        rdata
);

  fpba_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/fit_policy_block_allocator.sv =====
// Fit-policy block allocator top level: request sequencer around the block table.
// Depends on fpba_pkg and fpba_ram.
//
// One request at a time. The table sits in a single-port-read memory, so the
// sequencer reads and evaluates one entry at a time on the search (up to one
// pass over the table), and reads and writes back each entry moved when a
// split opens a slot or a merge closes one.
// The next request is taken while the previous result still waits on the
// output. After reset and after each accepted region_bytes write the table is
// rebuilt in the S_INIT state, during which no request is taken.
`default_nettype none

module fit_policy_block_allocator #(
  parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [39:0] s_tdata,   // req_size[16:0], req_address[32:17], zero pad
  input  wire [0:0]  s_tuser,   // req_type[0]
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [15:0] m_tdata,  // data_address[15:0]
  output logic [1:0]  m_tuser,  // status[1:0]
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire        cfg_index,
  input  wire [16:0] cfg_data
);

  localparam int IDXW = $clog2(MAX_BLOCKS);
  localparam int CNTW = IDXW + 1;
  localparam int AW   = fpba_pkg::ADDR_BITS;
  localparam int SW   = fpba_pkg::SIZE_BITS;
  localparam logic [CNTW-1:0] NONE = CNTW'(MAX_BLOCKS);
  localparam logic [SW-1:0]   HDR  = SW'(fpba_pkg::HEADER_BYTES);
  localparam logic [SW:0]     WRND = (SW+1)'(fpba_pkg::WORD_BYTES - 1);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_SCAN_RD, S_SCAN_EV, S_ALLOC, S_SH_RD, S_SH_WR,
    S_SPW1, S_SPW2, S_NXT_RD, S_NXT_EV, S_PRV_RD, S_PRV_EV, S_MERGE,
    S_RM_RD, S_RM_WR, S_RM_END, S_DONE
  } state_t;

  state_t          state;
  logic [1:0]      policy;
  logic [SW-1:0]   region;
  logic [CNTW-1:0] total;
  logic [CNTW-1:0] last;
  logic            req_t;
  logic [SW-1:0]   rsize;
  logic [AW-1:0]   raddr_q;
  logic [CNTW-1:0] p;
  logic [CNTW-1:0] cnt;
  logic            sel_found;
  logic [CNTW-1:0] sel_idx;
  logic [AW-1:0]   sel_off;
  logic [AW-1:0]   sel_size;
  logic            nf;
  logic            pf;
  logic [AW-1:0]   n_size;
  logic [AW-1:0]   p_off;
  logic [AW-1:0]   p_size;
  logic [CNTW-1:0] k;
  logic [CNTW-1:0] rm_r;
  logic            rm_second;
  logic [1:0]      res_status;
  logic [AW-1:0]   res_addr;
  logic            out_valid;
  logic [1:0]      out_status;
  logic [AW-1:0]   out_addr;

  logic             mem_we;
  logic [IDXW-1:0]  mem_waddr;
  logic [IDXW-1:0]  mem_raddr;
  fpba_pkg::entry_t mem_wdata;
  fpba_pkg::entry_t mem_rdata;

  fpba_ram #(.DEPTH(MAX_BLOCKS)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // request fields
  logic [SW-1:0] in_size;
  logic [AW-1:0] in_addr;
  logic [SW:0]   in_round;
  assign in_size  = s_tdata[16:0];
  assign in_addr  = s_tdata[32:17];
  assign in_round = ({1'b0, in_size} + WRND) & ~WRND;

  // scan evaluation
  logic          e_fit;
  logic          e_better;
  logic          e_match;
  logic [CNTW-1:0] p_inc;
  logic [CNTW-1:0] p_next;
  logic [CNTW-1:0] lp1;
  logic          split;
  logic [SW-1:0] sel_data_addr;
  logic [SW-1:0] spare;

  assign e_fit   = !mem_rdata.in_use && ({1'b0, mem_rdata.dsize} >= rsize);
  assign e_match = ({1'b0, mem_rdata.offset} + HDR) == {1'b0, raddr_q};
  assign p_inc   = p + CNTW'(1);
  assign p_next  = (p_inc >= total) ? '0 : p_inc;
  assign lp1     = last + CNTW'(1);
  assign spare   = {1'b0, sel_size} - rsize;
  assign split   = (total < NONE) && (spare >= HDR);
  assign sel_data_addr = {1'b0, sel_off} + HDR;

  always_comb begin
    case (policy)
      fpba_pkg::POL_BEST:  e_better = !sel_found || (mem_rdata.dsize < sel_size);
      fpba_pkg::POL_WORST: e_better = !sel_found || (mem_rdata.dsize > sel_size);
      default:             e_better = !sel_found;
    endcase
  end

  // table port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sel_idx[IDXW-1:0];
    mem_wdata = '0;
    mem_raddr = p[IDXW-1:0];
    case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = '{in_use: 1'b0, dsize: AW'(region - HDR), offset: '0};
      end
      S_ALLOC: begin
        mem_we    = !split;
        mem_wdata = '{in_use: 1'b1, dsize: sel_size, offset: sel_off};
      end
      S_SH_RD: mem_raddr = IDXW'(k - CNTW'(1));
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k[IDXW-1:0];
        mem_wdata = mem_rdata;
      end
      S_SPW1: begin
        mem_we    = 1'b1;
        mem_waddr = IDXW'(sel_idx + CNTW'(1));
        mem_wdata = '{in_use: 1'b0, dsize: AW'(spare - HDR),
                      offset: AW'(sel_data_addr + rsize)};
      end
      S_SPW2: begin
        mem_we    = 1'b1;
        mem_wdata = '{in_use: 1'b1, dsize: AW'(rsize), offset: sel_off};
      end
      S_NXT_RD: mem_raddr = IDXW'(sel_idx + CNTW'(1));
      S_PRV_RD: mem_raddr = IDXW'(sel_idx - CNTW'(1));
      S_MERGE: begin
        mem_we = 1'b1;
        if (pf) begin
          mem_waddr = IDXW'(sel_idx - CNTW'(1));
          mem_wdata = '{in_use: 1'b0, offset: p_off,
                        dsize: nf ? AW'(p_size + sel_size + n_size + AW'(2) * AW'(HDR))
                                  : AW'(p_size + sel_size + AW'(HDR))};
        end else if (nf) begin
          mem_wdata = '{in_use: 1'b0, offset: sel_off,
                        dsize: AW'(sel_size + n_size + AW'(HDR))};
        end else begin
          mem_wdata = '{in_use: 1'b0, dsize: sel_size, offset: sel_off};
        end
      end
      S_RM_RD: mem_raddr = IDXW'(k + CNTW'(1));
      S_RM_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k[IDXW-1:0];
        mem_wdata = mem_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      policy     <= fpba_pkg::POL_BEST;
      region     <= SW'(4096);
      total      <= CNTW'(1);
      last       <= NONE;
      out_valid  <= 1'b0;
      sel_found  <= 1'b0;
      rm_second  <= 1'b0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          total <= CNTW'(1);
          last  <= NONE;
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_tvalid) begin
            req_t     <= s_tuser[0];
            rsize     <= in_round[SW-1:0];
            raddr_q   <= in_addr;
            sel_found <= 1'b0;
            res_addr  <= '0;
            p         <= '0;
            cnt       <= total;
            state     <= S_SCAN_RD;
            if (s_tuser[0] == fpba_pkg::REQ_ALLOC) begin
              if (in_size == '0) begin
                res_status <= fpba_pkg::ST_BAD;
                state      <= S_DONE;
              end else if (in_round[SW]) begin
                // rounded size beyond any block
                res_status <= fpba_pkg::ST_NOFIT;
                state      <= S_DONE;
              end else if (policy == fpba_pkg::POL_NEXT && last != NONE) begin
                p   <= (lp1 >= total) ? '0 : lp1;
                cnt <= total - CNTW'(1);
                if (total == CNTW'(1)) begin
                  res_status <= fpba_pkg::ST_NOFIT;
                  state      <= S_DONE;
                end
              end
            end
          end
        end
        S_SCAN_RD: state <= S_SCAN_EV;
        S_SCAN_EV: begin
          p   <= p_next;
          cnt <= cnt - CNTW'(1);
          state <= S_SCAN_RD;
          if (req_t == fpba_pkg::REQ_ALLOC) begin
            if (e_fit && e_better) begin
              sel_found <= 1'b1;
              sel_idx   <= p;
              sel_off   <= mem_rdata.offset;
              sel_size  <= mem_rdata.dsize;
            end
            if (e_fit && (policy == fpba_pkg::POL_FIRST || policy == fpba_pkg::POL_NEXT)) begin
              state <= S_ALLOC;
            end else if (cnt == CNTW'(1)) begin
              if (sel_found || e_fit) begin
                state <= S_ALLOC;
              end else begin
                res_status <= fpba_pkg::ST_NOFIT;
                state      <= S_DONE;
              end
            end
          end else begin
            if (e_match) begin
              sel_idx  <= p;
              sel_off  <= mem_rdata.offset;
              sel_size <= mem_rdata.dsize;
              if (mem_rdata.in_use) begin
                state <= S_NXT_RD;
              end else begin
                res_status <= fpba_pkg::ST_BAD;
                state      <= S_DONE;
              end
            end else if (cnt == CNTW'(1)) begin
              res_status <= fpba_pkg::ST_BAD;
              state      <= S_DONE;
            end
          end
        end
        S_ALLOC: begin
          if (split) begin
            k <= total;
            state <= (total > sel_idx + CNTW'(1)) ? S_SH_RD : S_SPW1;
          end else begin
            last       <= sel_idx;
            res_status <= fpba_pkg::ST_OK;
            res_addr   <= sel_data_addr[AW-1:0];
            state      <= S_DONE;
          end
        end
        S_SH_RD: state <= S_SH_WR;
        S_SH_WR: begin
          k     <= k - CNTW'(1);
          state <= (k - CNTW'(1) > sel_idx + CNTW'(1)) ? S_SH_RD : S_SPW1;
        end
        S_SPW1: state <= S_SPW2;
        S_SPW2: begin
          total      <= total + CNTW'(1);
          last       <= sel_idx;
          res_status <= fpba_pkg::ST_OK;
          res_addr   <= sel_data_addr[AW-1:0];
          state      <= S_DONE;
        end
        S_NXT_RD: begin
          if (sel_idx + CNTW'(1) < total) begin
            state <= S_NXT_EV;
          end else begin
            nf    <= 1'b0;
            state <= S_PRV_RD;
          end
        end
        S_NXT_EV: begin
          nf     <= !mem_rdata.in_use;
          n_size <= mem_rdata.dsize;
          state  <= S_PRV_RD;
        end
        S_PRV_RD: begin
          if (sel_idx != '0) begin
            state <= S_PRV_EV;
          end else begin
            pf    <= 1'b0;
            state <= S_MERGE;
          end
        end
        S_PRV_EV: begin
          pf     <= !mem_rdata.in_use;
          p_off  <= mem_rdata.offset;
          p_size <= mem_rdata.dsize;
          state  <= S_MERGE;
        end
        S_MERGE: begin
          res_status <= fpba_pkg::ST_OK;
          if (nf) begin
            rm_r      <= sel_idx + CNTW'(1);
            k         <= sel_idx + CNTW'(1);
            rm_second <= pf;
            state     <= S_RM_RD;
          end else if (pf) begin
            rm_r      <= sel_idx;
            k         <= sel_idx;
            rm_second <= 1'b0;
            state     <= S_RM_RD;
          end else begin
            state <= S_DONE;
          end
        end
        // close the gap at rm_r by moving the upper entries down
        S_RM_RD: state <= (k + CNTW'(1) < total) ? S_RM_WR : S_RM_END;
        S_RM_WR: begin
          k     <= k + CNTW'(1);
          state <= S_RM_RD;
        end
        S_RM_END: begin
          total <= total - CNTW'(1);
          if (last != NONE && last >= rm_r) begin
            last <= last - CNTW'(1);
          end
          if (rm_second) begin
            rm_second <= 1'b0;
            rm_r      <= sel_idx;
            k         <= sel_idx;
            state     <= S_RM_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || m_tready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_addr   <= res_addr;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_valid) begin
        if (cfg_index == fpba_pkg::REG_POLICY) begin
          policy <= cfg_data[1:0];
        end else if ($onehot(cfg_data) && cfg_data >= SW'(4096)) begin
          region <= cfg_data;
          state  <= S_INIT;
        end
      end
    end
  end

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_addr;
  assign m_tuser   = out_status;

`ifndef SYNTHESIS
  a_total_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_INIT) |-> (total >= CNTW'(1) && total <= NONE))
    else $error("block count out of range");

  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (last == NONE || last < total))
    else $error("last allocated slot beyond table");

  a_err_no_addr: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != fpba_pkg::ST_OK) |-> (m_tdata == '0))
    else $error("address returned with failing status");
`endif

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking bench for fit_policy_block_allocator: random alloc/free traffic
// against a behavioral table allocator, with policy and region changes.
// Depends on fpba_pkg and the allocator RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int NSLOT = 64;
  localparam int HDR = 16;
  localparam int WATCHDOG = 20000;

  typedef struct {
    logic        kind;
    logic [16:0] size;
    logic [15:0] addr;
  } req_t;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] daddr;
  } resp_t;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, m_tready = 0, cfg_valid = 0, cfg_index = 0;
  logic [39:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic [16:0] cfg_data = '0;
  wire s_tready, m_tvalid, cfg_ready;
  wire [15:0] m_tdata;
  wire [1:0] m_tuser;

  fit_policy_block_allocator dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // allocator model state
  int unsigned blk_off[NSLOT], blk_size[NSLOT];
  bit blk_used[NSLOT];
  int unsigned blk_count, last_slot, policy, region;
  int unsigned live_addrs[$];

  req_t pending_reqs[$];
  resp_t expected_resps[$];
  int errors = 0, stall_ctr = 0;
  bit calm = 0;
  bit s_taken = 0;

  function automatic void reset_table();
    for (int i = 0; i < NSLOT; i++) begin
      blk_off[i] = 0; blk_size[i] = 0; blk_used[i] = 0;
    end
    blk_size[0] = region - HDR;
    blk_count = 1;
    last_slot = NSLOT;
    live_addrs.delete();
  endfunction

  function automatic void drop_entry(int unsigned r);
    for (int unsigned k = r; k + 1 < blk_count; k++) begin
      blk_off[k] = blk_off[k+1]; blk_size[k] = blk_size[k+1]; blk_used[k] = blk_used[k+1];
    end
    blk_count--;
    if (last_slot != NSLOT && last_slot >= r) last_slot--;
  endfunction

  function automatic bit can_hold(int unsigned i, int unsigned sz);
    return !blk_used[i] && blk_size[i] >= sz;
  endfunction

  function automatic int unsigned choose_block(int unsigned sz);
    int unsigned pick;
    int unsigned start;
    int unsigned stop;
    pick = NSLOT;
    case (policy[1:0])
      fpba_pkg::POL_BEST, fpba_pkg::POL_WORST: begin
        for (int unsigned i = 0; i < blk_count; i++)
          if (can_hold(i, sz) && (pick == NSLOT ||
              (policy[1:0] == fpba_pkg::POL_BEST ? blk_size[i] < blk_size[pick]
                                                 : blk_size[i] > blk_size[pick])))
            pick = i;
      end
      fpba_pkg::POL_FIRST: begin
        for (int unsigned i = 0; i < blk_count; i++)
          if (can_hold(i, sz)) return i;
      end
      default: begin
        start = (last_slot == NSLOT) ? 0 : last_slot + 1;
        for (int unsigned i = start; i < blk_count; i++)
          if (can_hold(i, sz)) return i;
        stop = (last_slot == NSLOT) ? blk_count : last_slot;
        for (int unsigned i = 0; i < stop && i < blk_count; i++)
          if (can_hold(i, sz)) return i;
      end
    endcase
    return pick;
  endfunction

  function automatic resp_t allocate_or_release(req_t r);
    resp_t o;
    int unsigned sz, j, i;
    o.status = fpba_pkg::ST_OK; o.daddr = '0;
    if (r.kind == fpba_pkg::REQ_ALLOC) begin
      if (r.size == 0) begin
        o.status = fpba_pkg::ST_BAD;
        return o;
      end
      sz = (int'(r.size) + 7) / 8 * 8;
      j = choose_block(sz);
      if (j == NSLOT) begin
        o.status = fpba_pkg::ST_NOFIT;
        return o;
      end
      if (blk_count < NSLOT && blk_size[j] - sz >= HDR) begin
        for (int unsigned k = blk_count; k > j + 1; k--) begin
          blk_off[k] = blk_off[k-1]; blk_size[k] = blk_size[k-1]; blk_used[k] = blk_used[k-1];
        end
        blk_off[j+1] = blk_off[j] + HDR + sz;
        blk_size[j+1] = blk_size[j] - sz - HDR;
        blk_used[j+1] = 0;
        blk_size[j] = sz;
        blk_count++;
      end
      blk_used[j] = 1;
      last_slot = j;
      o.daddr = 16'(blk_off[j] + HDR);
      live_addrs.push_back(o.daddr);
    end else begin
      for (i = 0; i < blk_count; i++)
        if (blk_off[i] + HDR == r.addr) break;
      if (i >= blk_count || !blk_used[i]) begin
        o.status = fpba_pkg::ST_BAD;
        return o;
      end
      blk_used[i] = 0;
      if (i + 1 < blk_count && !blk_used[i+1]) begin
        blk_size[i] += blk_size[i+1] + HDR;
        drop_entry(i + 1);
      end
      if (i > 0 && !blk_used[i-1]) begin
        blk_size[i-1] += blk_size[i] + HDR;
        drop_entry(i);
      end
    end
    return o;
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // request driver
  int s_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else if (!s_tvalid || s_taken) begin
      if (s_gap > 0) begin
        s_gap <= s_gap - 1;
        s_tvalid <= 0;
      end else if (pending_reqs.size() > 0) begin
        s_tvalid <= 1;
        s_tdata <= {7'd0, pending_reqs[0].addr, pending_reqs[0].size};
        s_tuser <= pending_reqs[0].kind;
        if (!calm && $urandom_range(0, 7) == 0) s_gap <= $urandom_range(1, 13);
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  // response side back-pressure
  int m_gap = 0;
  always @(negedge clk) begin
    if (m_gap > 0) begin
      m_gap <= m_gap - 1;
      m_tready <= 0;
    end else begin
      m_tready <= 1;
      if (!calm && $urandom_range(0, 7) == 0) m_gap <= $urandom_range(1, 13);
    end
  end

  // monitor: predicts at request acceptance, checks at response acceptance
  always @(posedge clk) begin
    resp_t want;
    s_taken <= !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_resps.push_back(allocate_or_release(pending_reqs.pop_front()));
      end
      if (m_tvalid && m_tready) begin
        if (expected_resps.size() == 0) begin
          report("unexpected response status", 16'(m_tuser), 16'd0);
        end else begin
          want = expected_resps.pop_front();
          if (m_tuser !== want.status) report("status", 16'(m_tuser), 16'(want.status));
          if (m_tdata !== want.daddr) report("data_address", m_tdata, want.daddr);
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        stall_ctr <= 0;
      else
        stall_ctr <= stall_ctr + 1;
      if (stall_ctr > WATCHDOG) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic push_req(logic kind, logic [16:0] size, logic [15:0] addr);
    req_t r;
    r.kind = kind; r.size = size; r.addr = addr;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    while (expected_resps.size() > 0 || s_tvalid) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [16:0] val);
    @(negedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    // model update at the accepting edge
    if (idx == fpba_pkg::REG_POLICY) policy = val[1:0];
    else if (val >= 4096 && val <= 65536 && (val & (val - 1)) == 0) begin
      region = val;
      reset_table();
    end
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // random mix: allocs of varied sizes and frees, mostly of earlier allocated addresses, some random
  task automatic random_phase(int n);
    int unsigned pos;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 9))
          0: push_req(fpba_pkg::REQ_ALLOC, 17'($urandom), 16'($urandom));
          1: push_req(fpba_pkg::REQ_ALLOC, 17'($urandom_range(0, 8)), 16'($urandom));
          default: push_req(fpba_pkg::REQ_ALLOC, 17'($urandom_range(1, 700)), 16'($urandom));
        endcase
      end else begin
        // predictor runs later; pick from currently known addresses plus noise
        pos = $urandom_range(0, 15);
        if (pos < 12 && live_addrs.size() > 0)
          push_req(fpba_pkg::REQ_FREE, 17'($urandom),
                   16'(live_addrs[$urandom_range(0, live_addrs.size() - 1)]));
        else push_req(fpba_pkg::REQ_FREE, 17'($urandom), 16'($urandom));
      end
      // let the model catch up so free addresses are mostly real
      if (pending_reqs.size() > 4) wait (pending_reqs.size() <= 2);
    end
  endtask

  initial begin
    policy = fpba_pkg::POL_BEST;
    region = 4096;
    reset_table();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: extremes, zero size, bad frees, split/no split edges
    push_req(fpba_pkg::REQ_ALLOC, 17'd0, 16'hffff);
    push_req(fpba_pkg::REQ_ALLOC, 17'd1, 16'd0);
    push_req(fpba_pkg::REQ_ALLOC, 17'h1ffff, 16'd0);
    push_req(fpba_pkg::REQ_ALLOC, 17'd65536, 16'd0);
    push_req(fpba_pkg::REQ_ALLOC, 17'd4080, 16'd0);
    push_req(fpba_pkg::REQ_FREE, 17'h1ffff, 16'd16);
    push_req(fpba_pkg::REQ_FREE, 17'd0, 16'd16);
    push_req(fpba_pkg::REQ_FREE, 17'd0, 16'hffff);
    push_req(fpba_pkg::REQ_FREE, 17'd0, 16'd0);
    push_req(fpba_pkg::REQ_ALLOC, 17'd4064, 16'd0);
    push_req(fpba_pkg::REQ_ALLOC, 17'd8, 16'd0);
    push_req(fpba_pkg::REQ_FREE, 17'd0, 16'd16);
    push_req(fpba_pkg::REQ_ALLOC, 17'd4072, 16'd0);
    push_req(fpba_pkg::REQ_FREE, 17'd0, 16'd16);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_reg(fpba_pkg::REG_POLICY, 17'($urandom) & 17'h1fffc | 17'(p));
      write_reg(fpba_pkg::REG_REGION, (p == 0) ? 17'd3000 : (p == 3) ? 17'd65536 :
                                      (p == 1) ? 17'd4096 : 17'd8192);
      // fill the table to its entry limit with small blocks
      for (int i = 0; i < 70; i++)
        push_req(fpba_pkg::REQ_ALLOC, 17'($urandom_range(1, 24)), '0);
      drain();
      random_phase(70);
      drain();
    end
    // tail without idling
    calm = 1;
    write_reg(fpba_pkg::REG_POLICY, 17'(fpba_pkg::POL_NEXT));
    write_reg(fpba_pkg::REG_REGION, 17'd16384);
    random_phase(90);
    drain();
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/fpba_pkg.sv
rtl/fpba_ram.sv
rtl/fit_policy_block_allocator.sv
test/testbench.sv
